// ===== rtl/chnd_pkg.sv =====
// Package for the context Huffman nibble decoder.
// Holds opcodes, status codes, the controller state type and the frame constants.
package chnd_pkg;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_LOAD   = 2'd1,
        OP_FINISH = 2'd2,
        OP_DATA   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_SYM   = 3'd1,
        ST_OVERLAP   = 3'd2,
        ST_UNCOVERED = 3'd3,
        ST_NOT_ARMED = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLEAR,
        S_CHECK,
        S_WRITE,
        S_SCAN,
        S_SCAN_CHK,
        S_HI_RD,
        S_HI_WAIT,
        S_LO_RD,
        S_LO_WAIT,
        S_EMIT,
        S_OUT
    } t_state;

    localparam int unsigned FRAME_BYTES = 9;
    localparam int unsigned TABLE_AW    = 10;
    localparam logic [1:0]  REG_TOTAL_FRAMES = 2'd0;

    // Memory request from the controller to the table memory.
    typedef struct packed {
        logic                wr_en;
        logic [TABLE_AW-1:0] addr;
        logic [7:0]          wdata;
    } t_mem_req;

endpackage

// ===== rtl/chnd_table_mem.sv =====
// Prefix table memory: three 256-entry tables of (symbol, length) bytes.
// Depends on chnd_pkg for the request struct; one port, registered read.
module chnd_table_mem (
    input  logic                i_clk,
    input  chnd_pkg::t_mem_req  i_req,
    output logic [7:0]          o_rdata
);
    logic [7:0] r_mem [0:767];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/context_huffman_nibble_decoder.sv =====
// Top level of the context Huffman nibble decoder: controller, bit buffer, APB register.
// Depends on chnd_pkg and chnd_table_mem.
//
//  channel   | valid    | stall    | payload
//  input     | i_valid  | o_stall  | i_op i_context_req i_symbol i_code_length ...
//  output    | o_valid  | i_stall  | o_kind o_status o_err_context o_err_position ...
//  config    | psel/penable/pwrite, pready always high
//
// One item at a time. A clear sweeps 768 table entries. A load checks up to 128
// slots and then writes them (one per cycle). Finish scans up to 768 entries. Each
// decoded byte passes through emit, two table reads with their waits, and the
// output state. Reset is synchronous and starts a clearing pass of all 768 table
// entries; the input stalls until it ends. Output stalls hold the controller until
// the result is taken.
module context_huffman_nibble_decoder #(
    parameter int unsigned FRAME_COUNT_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_op,
    input  logic [1:0]  i_context_req,
    input  logic [3:0]  i_symbol,
    input  logic [3:0]  i_code_length,
    input  logic [7:0]  i_code_value,
    input  logic [31:0] i_data_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [2:0]  o_status,
    output logic [1:0]  o_err_context,
    output logic [7:0]  o_err_position,
    output logic [7:0]  o_frame_byte,
    output logic [3:0]  o_byte_in_frame,
    output logic        o_last,
    output logic        o_stream_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    localparam int unsigned FCB = FRAME_COUNT_BITS;
    localparam logic [0:0] REG_IDX0 = chnd_pkg::REG_TOTAL_FRAMES[0:0];

    chnd_pkg::t_state   r_state, n_state;
    chnd_pkg::t_mem_req s_req;
    logic [7:0]         s_rdata;

    logic [FCB-1:0] r_total, r_frames;
    logic [63:0]    r_buf, n_buf;
    logic [6:0]     r_bits, n_bits;
    logic [3:0]     r_pos, n_pos;
    logic           r_armed, n_armed;
    logic [9:0]     r_idx, n_idx;
    logic [8:0]     r_cnt, n_cnt;
    logic [3:0]     r_sym, r_len;
    logic [3:0]     r_hi, n_hi;
    logic [FCB-1:0] n_frames;
    logic           r_boot;

    logic       r_ovalid, n_ovalid;
    logic       r_kind, n_kind;
    logic [2:0] r_status, n_status;
    logic [1:0] r_ectx, n_ectx;
    logic [7:0] r_epos, n_epos;
    logic [7:0] r_fbyte, n_fbyte;
    logic [3:0] r_bif, n_bif;
    logic       r_last, n_last;
    logic       r_done, n_done;

    logic       in_acc, cfg_wr, more;
    logic [8:0] span;
    logic [7:0] base, peek;
    logic [1:0] tsel;

    chnd_table_mem u_mem (.i_clk(i_clk), .i_req(s_req), .o_rdata(s_rdata));

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite
                    && (paddr[2:2] == REG_IDX0) && (paddr[1:0] == 2'd0);
    always_comb begin
        prdata = '0;
        if (paddr[2] == 1'b0) prdata[FCB-1:0] = r_total;
    end

    assign o_stall = (r_state != chnd_pkg::S_IDLE) || r_ovalid;
    assign in_acc  = i_valid && !o_stall;
    assign o_valid = r_ovalid;
    assign o_kind = r_kind;
    assign o_status = r_status;
    assign o_err_context = r_ectx;
    assign o_err_position = r_epos;
    assign o_frame_byte = r_fbyte;
    assign o_byte_in_frame = r_bif;
    assign o_last = r_last;
    assign o_stream_done = r_done;

    assign span = 9'd1 << (4'd8 - r_len);
    assign base = r_idx[7:0];
    assign peek = 8'(r_buf >> (r_bits - 7'd8));
    assign tsel = (r_pos == 4'd0) ? 2'd0 : 2'd2;
    assign more = (r_bits >= 7'd32) && (r_frames < r_total);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
        end else if (cfg_wr) begin
            r_total <= FCB'(pwdata[23:0]);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            chnd_pkg::S_IDLE: begin
                if (in_acc) begin
                    unique case (chnd_pkg::t_op'(i_op))
                        chnd_pkg::OP_CLEAR:  n_state = chnd_pkg::S_CLEAR;
                        chnd_pkg::OP_LOAD:
                            n_state = (i_code_length == 4'hF || i_context_req == 2'd3
                                       || i_code_length == 4'd0 || i_code_length > 4'd8
                                       || (({8'd0, i_code_value} >> i_code_length) != 16'd0))
                                      ? chnd_pkg::S_OUT : chnd_pkg::S_CHECK;
                        chnd_pkg::OP_FINISH: n_state = chnd_pkg::S_SCAN;
                        chnd_pkg::OP_DATA: begin
                            // drop the word silently once the stream is finished
                            if (!r_armed) n_state = chnd_pkg::S_OUT;
                            else if (r_frames < r_total) n_state = chnd_pkg::S_EMIT;
                        end
                        default: n_state = chnd_pkg::S_OUT;
                    endcase
                end
            end
            chnd_pkg::S_CLEAR: begin
                if (r_idx == 10'd767) n_state = r_boot ? chnd_pkg::S_IDLE : chnd_pkg::S_OUT;
            end
            chnd_pkg::S_CHECK: begin
                if (r_cnt != 9'd0 && s_rdata != 8'd0) n_state = chnd_pkg::S_OUT;
                else if (r_cnt == span) n_state = chnd_pkg::S_WRITE;
            end
            chnd_pkg::S_WRITE: if (r_cnt == span - 9'd1) n_state = chnd_pkg::S_OUT;
            chnd_pkg::S_SCAN:  n_state = chnd_pkg::S_SCAN_CHK;
            chnd_pkg::S_SCAN_CHK: begin
                if (s_rdata == 8'd0 || r_idx == 10'd767) n_state = chnd_pkg::S_OUT;
                else n_state = chnd_pkg::S_SCAN;
            end
            chnd_pkg::S_HI_RD:   n_state = chnd_pkg::S_HI_WAIT;
            chnd_pkg::S_HI_WAIT: n_state = chnd_pkg::S_LO_RD;
            chnd_pkg::S_LO_RD:   n_state = chnd_pkg::S_LO_WAIT;
            chnd_pkg::S_LO_WAIT: n_state = chnd_pkg::S_OUT;
            chnd_pkg::S_EMIT:    n_state = more ? chnd_pkg::S_HI_RD : chnd_pkg::S_IDLE;
            chnd_pkg::S_OUT: begin
                if (!r_ovalid) n_state = (r_kind && !r_last) ? chnd_pkg::S_EMIT
                                                              : chnd_pkg::S_IDLE;
                else if (!i_stall)
                    n_state = (r_kind && !r_last) ? chnd_pkg::S_EMIT : chnd_pkg::S_IDLE;
            end
            default: n_state = chnd_pkg::S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_buf = r_buf; n_bits = r_bits; n_pos = r_pos; n_armed = r_armed;
        n_idx = r_idx; n_cnt = r_cnt; n_hi = r_hi; n_frames = r_frames;
        n_ovalid = r_ovalid && i_stall;
        n_kind = r_kind; n_status = r_status; n_ectx = r_ectx; n_epos = r_epos;
        n_fbyte = r_fbyte; n_bif = r_bif; n_last = r_last; n_done = r_done;
        s_req = '{wr_en: 1'b0, addr: r_idx, wdata: {r_sym, r_len}};
        unique case (r_state)
            chnd_pkg::S_IDLE: begin
                n_kind = 1'b0; n_status = chnd_pkg::ST_OK; n_ectx = '0; n_epos = '0;
                n_fbyte = '0; n_bif = '0; n_last = 1'b1; n_done = 1'b0;
                n_idx = '0; n_cnt = '0;
                if (in_acc) begin
                    unique case (chnd_pkg::t_op'(i_op))
                        chnd_pkg::OP_CLEAR: begin
                            n_buf = '0; n_bits = '0; n_pos = '0; n_frames = '0;
                            n_armed = 1'b0;
                        end
                        chnd_pkg::OP_LOAD: begin
                            n_armed = 1'b0;
                            n_idx = {i_context_req,
                                     8'(i_code_value << (4'd8 - i_code_length))};
                            if (i_code_length != 4'hF && (i_context_req == 2'd3
                                || i_code_length == 4'd0 || i_code_length > 4'd8
                                || (({8'd0, i_code_value} >> i_code_length) != 16'd0)))
                            begin
                                n_status = chnd_pkg::ST_BAD_SYM;
                                n_ectx = i_context_req; n_epos = {4'd0, i_symbol};
                            end
                        end
                        chnd_pkg::OP_FINISH: ;
                        chnd_pkg::OP_DATA: begin
                            if (!r_armed) n_status = chnd_pkg::ST_NOT_ARMED;
                            else if (r_frames < r_total) begin
                                n_buf = {r_buf[31:0], i_data_word};
                                n_bits = r_bits + 7'd32;
                                n_last = 1'b0; n_kind = 1'b1;
                            end else n_last = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            chnd_pkg::S_CLEAR: begin
                s_req = '{wr_en: 1'b1, addr: r_idx, wdata: 8'd0};
                n_idx = r_idx + 10'd1;
            end
            chnd_pkg::S_CHECK: begin
                // read slot cnt while checking the previous one
                s_req.addr = {r_idx[9:8], base + r_cnt[7:0]};
                if (r_cnt != 9'd0 && s_rdata != 8'd0) begin
                    n_status = chnd_pkg::ST_OVERLAP; n_ectx = r_idx[9:8];
                    n_epos = base + r_cnt[7:0] - 8'd1;
                end else if (r_cnt == span) n_cnt = '0;
                else n_cnt = r_cnt + 9'd1;
            end
            chnd_pkg::S_WRITE: begin
                s_req = '{wr_en: 1'b1, addr: {r_idx[9:8], base + r_cnt[7:0]},
                          wdata: {r_sym, r_len}};
                n_cnt = r_cnt + 9'd1;
            end
            chnd_pkg::S_SCAN: s_req.addr = r_idx;
            chnd_pkg::S_SCAN_CHK: begin
                if (s_rdata == 8'd0) begin
                    n_status = chnd_pkg::ST_UNCOVERED;
                    n_ectx = r_idx[9:8]; n_epos = r_idx[7:0];
                end else if (r_idx == 10'd767) n_armed = 1'b1;
                else n_idx = r_idx + 10'd1;
            end
            chnd_pkg::S_HI_RD: s_req.addr = {tsel, peek};
            chnd_pkg::S_HI_WAIT: begin
                n_hi = s_rdata[7:4];
                n_bits = (7'(s_rdata[3:0]) <= r_bits) ? r_bits - 7'(s_rdata[3:0]) : '0;
            end
            chnd_pkg::S_LO_RD: s_req.addr = {(r_pos == 4'd0) ? 2'd1 : 2'd2, peek};
            chnd_pkg::S_LO_WAIT: begin
                n_bits = (7'(s_rdata[3:0]) <= r_bits) ? r_bits - 7'(s_rdata[3:0]) : '0;
                n_fbyte = {r_hi, s_rdata[7:4]};
                n_bif = r_pos; n_kind = 1'b1; n_done = 1'b0;
                if (r_pos == 4'(chnd_pkg::FRAME_BYTES - 1)) begin
                    n_pos = '0;
                    n_frames = r_frames + 1'b1;
                    n_done = (r_frames + 1'b1) >= r_total;
                end else n_pos = r_pos + 4'd1;
                // last when no further byte follows
                n_last = !((n_bits >= 7'd32) && (n_frames < r_total));
            end
            chnd_pkg::S_EMIT: ;
            chnd_pkg::S_OUT: if (!r_ovalid || !i_stall) n_ovalid = 1'b0;
            default: ;
        endcase
        if (r_state == chnd_pkg::S_OUT && !r_ovalid) n_ovalid = 1'b0;
        if (n_state == chnd_pkg::S_OUT && r_state != chnd_pkg::S_OUT) n_ovalid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            // sweep the tables to zero before taking any transaction
            r_state <= chnd_pkg::S_CLEAR;
            r_idx <= '0;
            r_boot <= 1'b1;
            r_ovalid <= 1'b0;
            r_buf <= '0; r_bits <= '0; r_pos <= '0; r_armed <= 1'b0; r_frames <= '0;
        end else begin
            r_state <= n_state;
            r_idx <= n_idx;
            if (r_state == chnd_pkg::S_CLEAR && r_idx == 10'd767) r_boot <= 1'b0;
            r_ovalid <= n_ovalid;
            r_buf <= n_buf; r_bits <= n_bits; r_pos <= n_pos;
            r_armed <= n_armed; r_frames <= n_frames;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt; r_hi <= n_hi;
        r_kind <= n_kind; r_status <= n_status; r_ectx <= n_ectx; r_epos <= n_epos;
        r_fbyte <= n_fbyte; r_bif <= n_bif; r_last <= n_last; r_done <= n_done;
        if (in_acc) begin
            r_sym <= i_symbol; r_len <= i_code_length;
        end
    end
endmodule

// ===== verif/context_huffman_nibble_decoder_test.sv =====
// Testbench for context_huffman_nibble_decoder: directed table and error cases, then
// random prefix codes and compressed streams checked against an in-bench decoder model.
// Depends on chnd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module context_huffman_nibble_decoder_test;

    localparam int LIMIT_CYCLES = 3000000;
    localparam int SETTLE_CYCLES = 120;
    localparam logic [23:0] FRAMES_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic       kind;
        logic [2:0] status;
        logic [1:0] err_context;
        logic [7:0] err_position;
        logic [7:0] frame_byte;
        logic [3:0] byte_in_frame;
        logic       last;
        logic       stream_done;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_op = chnd_pkg::OP_CLEAR;
    logic [1:0]  i_context_req = '0;
    logic [3:0]  i_symbol = '0;
    logic [3:0]  i_code_length = '0;
    logic [7:0]  i_code_value = '0;
    logic [31:0] i_data_word = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic        o_kind;
    logic [2:0]  o_status;
    logic [1:0]  o_err_context;
    logic [7:0]  o_err_position;
    logic [7:0]  o_frame_byte;
    logic [3:0]  o_byte_in_frame;
    logic        o_last;
    logic        o_stream_done;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    context_huffman_nibble_decoder DUT (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Decoder model state
    logic [7:0]  code_table [3][256];
    logic [63:0] bit_buf;
    int          bit_count;
    logic [23:0] frames_out;
    int          frame_pos;
    bit          tables_armed;
    logic [23:0] frame_goal = '0;

    t_result     pending_results[$];
    int          error_count = 0;
    int          cycle_count = 0;
    bit          calm = 1'b0;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("context_huffman_nibble_decoder test failed");
            $finish;
        end
    end

    function automatic t_result status_result(chnd_pkg::t_status st, logic [1:0] ctx,
                                              logic [7:0] pos);
        t_result r;
        r = '0;
        r.status = st;
        r.err_context = ctx;
        r.err_position = pos;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic logic [3:0] take_nibble(int t);
        logic [7:0] idx;
        logic [7:0] e;
        idx = 8'(bit_buf >> (bit_count - 8));
        e = code_table[t][idx];
        bit_count = (e[3:0] <= bit_count) ? bit_count - e[3:0] : 0;
        return e[7:4];
    endfunction

    task automatic decode_predict(chnd_pkg::t_op op, logic [1:0] ctx, logic [3:0] sym,
                                  logic [3:0] len, logic [7:0] val, logic [31:0] word);
        int span;
        int base;
        int n;
        logic [3:0] hi;
        logic [3:0] lo;
        t_result r;
        t_result burst[$];
        case (op)
            chnd_pkg::OP_CLEAR: begin
                foreach (code_table[c, p]) code_table[c][p] = '0;
                bit_buf = '0;
                bit_count = 0;
                frames_out = '0;
                frame_pos = 0;
                tables_armed = 1'b0;
                pending_results.push_back(status_result(chnd_pkg::ST_OK, 0, 0));
            end
            chnd_pkg::OP_LOAD: begin
                tables_armed = 1'b0;
                if (len == 4'd15) begin
                    pending_results.push_back(status_result(chnd_pkg::ST_OK, 0, 0));
                end else if (ctx > 2 || len == 0 || len > 8 || (val >> len) != 0) begin
                    pending_results.push_back(status_result(chnd_pkg::ST_BAD_SYM, ctx,
                                                            {4'd0, sym}));
                end else begin
                    span = 1 << (8 - len);
                    base = val << (8 - len);
                    for (int k = 0; k < span; k++) begin
                        if (code_table[ctx][base + k] != 0) begin
                            pending_results.push_back(status_result(chnd_pkg::ST_OVERLAP,
                                                                    ctx, 8'(base + k)));
                            return;
                        end
                    end
                    for (int k = 0; k < span; k++) code_table[ctx][base + k] = {sym, len};
                    pending_results.push_back(status_result(chnd_pkg::ST_OK, 0, 0));
                end
            end
            chnd_pkg::OP_FINISH: begin
                for (int c = 0; c < 3; c++) begin
                    for (int p = 0; p < 256; p++) begin
                        if (code_table[c][p] == 0) begin
                            tables_armed = 1'b0;
                            pending_results.push_back(
                                status_result(chnd_pkg::ST_UNCOVERED, 2'(c), 8'(p)));
                            return;
                        end
                    end
                end
                tables_armed = 1'b1;
                pending_results.push_back(status_result(chnd_pkg::ST_OK, 0, 0));
            end
            default: begin
                if (!tables_armed) begin
                    pending_results.push_back(status_result(chnd_pkg::ST_NOT_ARMED, 0, 0));
                    return;
                end
                if (frames_out >= frame_goal) return;
                bit_buf = {bit_buf[31:0], word};
                bit_count += 32;
                n = 0;
                while (bit_count >= 32 && frames_out < frame_goal && n < 16) begin
                    r = '0;
                    r.kind = 1'b1;
                    r.byte_in_frame = 4'(frame_pos);
                    if (frame_pos == 0) begin
                        hi = take_nibble(0);
                        lo = take_nibble(1);
                    end else begin
                        hi = take_nibble(2);
                        lo = take_nibble(2);
                    end
                    r.frame_byte = {hi, lo};
                    if (frame_pos + 1 >= chnd_pkg::FRAME_BYTES) begin
                        frame_pos = 0;
                        frames_out = frames_out + 1;
                        r.stream_done = (frames_out >= frame_goal);
                    end else begin
                        frame_pos++;
                    end
                    burst.push_back(r);
                    n++;
                end
                if (n > 0) burst[n-1].last = 1'b1;
                foreach (burst[i]) pending_results.push_back(burst[i]);
            end
        endcase
    endtask

    // Called at a rising edge; returns at the edge where the transaction is accepted.
    task automatic send_item(chnd_pkg::t_op op, logic [1:0] ctx, logic [3:0] sym,
                             logic [3:0] len, logic [7:0] val, logic [31:0] word);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_op <= op;
        i_context_req <= ctx;
        i_symbol <= sym;
        i_code_length <= len;
        i_code_value <= val;
        i_data_word <= word;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        decode_predict(op, ctx, sym, len, val, word);
    endtask

    task automatic load_code(logic [1:0] ctx, logic [3:0] sym, logic [3:0] len, logic [7:0] val);
        send_item(chnd_pkg::OP_LOAD, ctx, sym, len, val, $urandom);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_goal(logic [23:0] v);
        settle();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 3'(chnd_pkg::REG_TOTAL_FRAMES * 4);
        pwdata <= {8'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        frame_goal = v;
    endtask

    // Load a random complete prefix code into one context, plus one unused symbol.
    task automatic load_random_code(logic [1:0] ctx);
        int leaf_len[16];
        int leaf_code[16];
        int nleaf;
        int target;
        int i;
        int j;
        int tmp;
        int order[16];
        leaf_len[0] = 1;
        leaf_code[0] = 0;
        leaf_len[1] = 1;
        leaf_code[1] = 1;
        nleaf = 2;
        target = $urandom_range(2, 12);
        while (nleaf < target) begin
            i = $urandom_range(0, nleaf - 1);
            if (leaf_len[i] < 8) begin
                leaf_len[i]++;
                leaf_code[i] = leaf_code[i] << 1;
                leaf_len[nleaf] = leaf_len[i];
                leaf_code[nleaf] = leaf_code[i] | 1;
                nleaf++;
            end
        end
        for (i = 0; i < 16; i++) order[i] = i;
        for (i = 15; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (i = 0; i < nleaf; i++)
            load_code(ctx, 4'(order[i]), 4'(leaf_len[i]), 8'(leaf_code[i]));
        if (nleaf < 16) load_code(ctx, 4'(order[nleaf]), 4'd15, 8'($urandom));
    endtask

    // Result side: random stall, then take and compare one transaction.
    initial begin
        int w;
        t_result got;
        t_result want;
        forever begin
            w = calm ? 0 : $urandom_range(0, 14);
            if (w > 0) begin
                i_stall <= 1'b1;
                repeat (w) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            got = {o_kind, o_status, o_err_context, o_err_position, o_frame_byte,
                   o_byte_in_frame, o_last, o_stream_done};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, got);
                    error_count++;
                end
            end
        end
    end

    task automatic test_table_errors();
        send_item(chnd_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        load_code(0, 4'd1, 4'd1, 8'd0);
        load_code(0, 4'd2, 4'd2, 8'd0);          // overlap at prefix 0
        load_code(1, 4'd15, 4'd8, 8'hFF);
        load_code(2, 4'd3, 4'd0, 8'd0);          // zero length
        load_code(2, 4'd4, 4'd9, 8'd1);          // length too long
        load_code(1, 4'd5, 4'd3, 8'd8);          // code wider than length
        load_code(2'd3, 4'd6, 4'd2, 8'd1);       // no such context
        load_code(0, 4'd7, 4'd15, 8'hFF);        // unused symbol
        send_item(chnd_pkg::OP_FINISH, 0, 0, 0, 0, 0);
        send_item(chnd_pkg::OP_DATA, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(chnd_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
    endtask

    // Shortest codes: every context one bit per nibble.
    task automatic test_short_codes();
        write_frame_goal(24'd2);
        send_item(chnd_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
        for (int c = 0; c < 3; c++) begin
            load_code(2'(c), 4'd0, 4'd1, 8'd0);
            load_code(2'(c), 4'd15, 4'd1, 8'd1);
        end
        send_item(chnd_pkg::OP_FINISH, 0, 0, 0, 0, 0);
        send_item(chnd_pkg::OP_DATA, 0, 0, 0, 0, 32'hA5A5_A5A5);
        send_item(chnd_pkg::OP_DATA, 0, 0, 0, 0, 32'h0000_0000);
        send_item(chnd_pkg::OP_DATA, 0, 0, 0, 0, 32'hFFFF_FFFF);
        send_item(chnd_pkg::OP_DATA, 0, 0, 0, 0, 32'h1234_5678);
    endtask

    task automatic test_random_streams();
        logic [23:0] goal;
        int words;
        for (int ph = 0; ph < 3; ph++) begin
            calm = (ph == 2);
            case (ph)
                0: goal = 24'd0;
                1: goal = FRAMES_MAX;
                default: goal = 24'($urandom_range(1, 4));
            endcase
            write_frame_goal(goal);
            send_item(chnd_pkg::OP_CLEAR, 0, 0, 0, 0, 0);
            for (int c = 0; c < 3; c++) load_random_code(2'(c));
            if ($urandom_range(0, 1))
                send_item(chnd_pkg::OP_LOAD, 2'($urandom), 4'($urandom), 4'($urandom),
                          8'($urandom), 0);
            send_item(chnd_pkg::OP_FINISH, 0, 0, 0, 0, 0);
            words = $urandom_range(6, 10);
            for (int k = 0; k < words; k++) begin
                if (k == words / 2) send_item(chnd_pkg::OP_FINISH, 0, 0, 0, 0, 0);
                send_item(chnd_pkg::OP_DATA, 0, 0, 0, 0,
                          ($urandom_range(0, 7) == 0) ? 32'd0 : $urandom);
            end
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_table_errors();
        test_short_codes();
        test_random_streams();
        settle();
        if (error_count == 0) begin
            $display("context_huffman_nibble_decoder test passed");
        end else begin
            $display("context_huffman_nibble_decoder test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/chnd_pkg.sv
rtl/chnd_table_mem.sv
rtl/context_huffman_nibble_decoder.sv
verif/context_huffman_nibble_decoder_test.sv
